// ===== hw/rtl/tvlk_pkg.sv =====
// Shared types and constants for the tallest vertical line keeper.
`timescale 1ns / 1ps
`default_nettype none

package tvlk_pkg;

    // Configuration register width and index width
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_WIDTH_LIMIT = 12'd10;
    localparam logic [CFG_W-1:0] RST_OVERLAP     = 12'd10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_LIMIT = 2'd0,
        CFG_OVERLAP     = 2'd1
    } t_cfg_reg;

    // Field positions inside a packed segment, lowest first
    localparam int FLD_SX     = 0;
    localparam int FLD_SY     = 1;
    localparam int FLD_EX     = 2;
    localparam int FLD_EY     = 3;
    localparam int NUM_FIELDS = 4;

    // Live configuration handed to the table logic
    typedef struct packed {
        logic [CFG_W-1:0] width_limit;
        logic [CFG_W-1:0] overlap;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/tallest_vertical_line_keeper.sv =====
// Top level of the tallest vertical line keeper.
//
// Usage:
//   Slave stream: one line segment per transaction. tdata carries start_x,
//   start_y, end_x, end_y from the low bits; tlast marks the frame's last
//   segment. Segments wider than the width limit are dropped; the rest go
//   into a height-ordered table of up to MAX_KEPT entries with overlap removal.
//   Master stream: on frame end the kept segments are sent tallest first,
//   one per transaction, with rank and count; tlast on the final one. An
//   empty frame yields one all-zero result with tlast set.
//   Config channel: index 0 width limit, 1 overlap distance; always ready.
// Timing:
//   One segment per cycle sustained, but for a waiting frame end. The table
//   update is combinational compare and select logic between the input
//   register and the table. The first result is valid once the frame's last
//   segment has been loaded from the input register into the output run.
//   A frame end waits in the input register while the previous run of up to
//   MAX_KEPT results is still being drained; slave tready drops meanwhile.
// Reset: synchronous, active low; empties the table, clears both streams
//   and sets both registers to 10.
`timescale 1ns / 1ps
`default_nettype none

module tallest_vertical_line_keeper #(
    parameter int MAX_KEPT   = 4,
    parameter int COORD_BITS = 12
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // slave stream; tdata: start_x, start_y, end_x, end_y
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire [((4*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  wire                              i_s_axis_tlast,
    // master stream; tdata: out_start_x, out_start_y, out_end_x, out_end_y,
    // rank, kept_count
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    output logic [((4*COORD_BITS + ((MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1)
                   + $clog2(MAX_KEPT+1) + 7)/8)*8-1:0] o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    // configuration writes
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [tvlk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [tvlk_pkg::CFG_W-1:0]        i_cfg_data
);
    import tvlk_pkg::*;

    localparam int SEG_W       = NUM_FIELDS * COORD_BITS;
    localparam int CNT_W       = $clog2(MAX_KEPT + 1);
    localparam int RANK_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int OUT_TDATA_W = ((SEG_W + RANK_W + CNT_W + 7) / 8) * 8;

    logic                           r_in_valid;
    logic [SEG_W-1:0]               r_in_seg;
    logic                           r_in_last;
    t_cfg                           r_cfg;

    logic                           fire;
    logic                           can_load;
    logic [MAX_KEPT-1:0][SEG_W-1:0] tbl_seg;
    logic [CNT_W-1:0]               tbl_count;

    // Input register advances unless a frame end must wait for the output run
    assign fire            = r_in_valid && (!r_in_last || can_load);
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_seg  <= i_s_axis_tdata[SEG_W-1:0];
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Configuration registers; unknown indexes are ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_limit <= RST_WIDTH_LIMIT;
            r_cfg.overlap     <= RST_OVERLAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH_LIMIT: r_cfg.width_limit <= i_cfg_data;
                CFG_OVERLAP:     r_cfg.overlap     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Segment table
    tvlk_table #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS),
        .SEG_W      (SEG_W),
        .CNT_W      (CNT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_seg   (r_in_seg),
        .i_last  (r_in_last),
        .i_cfg   (r_cfg),
        .o_seg   (tbl_seg),
        .o_count (tbl_count)
    );

    // Output run
    tvlk_emit #(
        .MAX_KEPT    (MAX_KEPT),
        .SEG_W       (SEG_W),
        .CNT_W       (CNT_W),
        .RANK_W      (RANK_W),
        .OUT_TDATA_W (OUT_TDATA_W)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && r_in_last),
        .i_seg      (tbl_seg),
        .i_count    (tbl_count),
        .o_can_load (can_load),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata),
        .o_tlast    (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tvlk_table.sv =====
// Height-ordered segment table: insert, overlap removal and frame clear.
`timescale 1ns / 1ps
`default_nettype none

module tvlk_table #(
    parameter int MAX_KEPT   = 4,
    parameter int COORD_BITS = 12,
    parameter int SEG_W      = 48,
    parameter int CNT_W      = 3
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_fire,
    input  wire [SEG_W-1:0]             i_seg,
    input  wire                         i_last,
    input  tvlk_pkg::t_cfg              i_cfg,
    output logic [MAX_KEPT-1:0][SEG_W-1:0] o_seg,
    output logic [CNT_W-1:0]            o_count
);
    import tvlk_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CMP_W = (C > CFG_W) ? C : CFG_W;
    localparam int RUN_W = CNT_W + 1;

    logic [MAX_KEPT-1:0][SEG_W-1:0] r_seg;
    logic [MAX_KEPT-1:0][SEG_W-1:0] n_seg;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;

    logic [C-1:0]                   sx;
    logic [C-1:0]                   h;
    logic                           wide_ok;
    logic                           found;
    logic [CNT_W-1:0]               pos;
    logic                           place;
    logic [MAX_KEPT:0][SEG_W-1:0]   tmp;
    logic [MAX_KEPT:0]              keep;
    logic [RUN_W-1:0]               run;

    function automatic logic [C-1:0] absd(input logic [C-1:0] a, input logic [C-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [C-1:0] fld(input logic [SEG_W-1:0] s, input int k);
        return s[k*C +: C];
    endfunction

    // Insertion point, overlap marks and compaction
    always_comb begin
        sx      = fld(i_seg, FLD_SX);
        h       = absd(fld(i_seg, FLD_EY), fld(i_seg, FLD_SY));
        wide_ok = CMP_W'(absd(fld(i_seg, FLD_EX), sx)) <= CMP_W'(i_cfg.width_limit);

        // first stored entry strictly shorter than the new one
        found = 1'b0;
        pos   = r_count;
        for (int i = MAX_KEPT - 1; i >= 0; i--) begin
            if (CNT_W'(i) < r_count &&
                absd(fld(r_seg[i], FLD_EY), fld(r_seg[i], FLD_SY)) < h) begin
                found = 1'b1;
                pos   = CNT_W'(i);
            end
        end
        place = wide_ok && (found || (r_count < CNT_W'(MAX_KEPT)));

        // table with the new segment spliced in at pos
        for (int i = 0; i <= MAX_KEPT; i++) begin
            if (CNT_W'(i) < pos) begin
                tmp[i] = (i < MAX_KEPT) ? r_seg[(i < MAX_KEPT) ? i : 0] : '0;
            end else if (CNT_W'(i) == pos) begin
                tmp[i] = i_seg;
            end else begin
                tmp[i] = r_seg[(i > 0) ? i - 1 : 0];
            end
            keep[i] = (CNT_W'(i) <= r_count) &&
                      ((CNT_W'(i) == pos) ||
                       !(CMP_W'(absd(fld(tmp[i], FLD_SX), sx)) < CMP_W'(i_cfg.overlap)));
        end

        // pack survivors from the top, cut to table depth
        n_seg = r_seg;
        run   = '0;
        for (int i = 0; i <= MAX_KEPT; i++) begin
            if (keep[i]) begin
                if (run < RUN_W'(MAX_KEPT)) begin
                    n_seg[run[IDX_W-1:0]] = tmp[i];
                end
                run = run + 1'b1;
            end
        end

        if (place) begin
            n_count = (run > RUN_W'(MAX_KEPT)) ? CNT_W'(MAX_KEPT) : run[CNT_W-1:0];
        end else begin
            n_seg   = r_seg;
            n_count = r_count;
        end
    end

    // Table after this segment, seen by the output stage on frame end
    assign o_seg   = n_seg;
    assign o_count = n_count;

    // Entries need no reset, only the fill count does
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_seg <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= i_last ? '0 : n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tvlk_emit.sv =====
// Output run buffer: holds a frame's kept segments and sends them one per beat.
`timescale 1ns / 1ps
`default_nettype none

module tvlk_emit #(
    parameter int MAX_KEPT    = 4,
    parameter int SEG_W       = 48,
    parameter int CNT_W       = 3,
    parameter int RANK_W      = 2,
    parameter int OUT_TDATA_W = 56
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_load,
    input  wire [MAX_KEPT-1:0][SEG_W-1:0]  i_seg,
    input  wire [CNT_W-1:0]                i_count,
    output logic                           o_can_load,
    output logic                           o_tvalid,
    input  wire                            i_tready,
    output logic [OUT_TDATA_W-1:0]         o_tdata,
    output logic                           o_tlast
);
    import tvlk_pkg::*;

    localparam int PAY_W = SEG_W + RANK_W + CNT_W;

    logic [MAX_KEPT-1:0][SEG_W-1:0] r_seg;
    logic [CNT_W-1:0]               r_count;
    logic [RANK_W-1:0]              r_idx;
    logic                           r_busy;

    logic                           last_beat;
    logic                           pop;
    logic [SEG_W-1:0]               cur_seg;

    // Beat bookkeeping
    always_comb begin
        last_beat  = (r_count == '0) || ((CNT_W'(r_idx) + 1'b1) == r_count);
        pop        = r_busy && i_tready;
        o_can_load = !r_busy || (pop && last_beat);
        cur_seg    = (r_count == '0) ? '0 : r_seg[r_idx];
    end

    // Snapshot of the table, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seg   <= i_seg;
            r_count <= i_count;
        end
    end

    // Run control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (pop) begin
            if (last_beat) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Result beat: segment, rank, count, padded to bytes
    assign o_tvalid = r_busy;
    assign o_tlast  = last_beat;
    assign o_tdata  = OUT_TDATA_W'({r_count, r_idx, cur_seg});

    // keeps the padding width tied to the payload
    if (OUT_TDATA_W < PAY_W) begin : g_bad_width
        $error("output tdata narrower than payload");
    end

endmodule

`default_nettype wire
